>>> hdl/kts_pkg.sv
`timescale 1ns / 1ps
package kts_pkg;

    localparam int MAX_KEY_BYTES_DEF = 16;

    localparam logic [7:0] HDR_VERSION   = 8'h21;
    localparam logic [7:0] HDR_SALT_BASE = 8'h20;
    localparam logic [7:0] SYM_BASE      = 8'd32;
    localparam logic [7:0] CNT_INIT      = 8'd11;
    localparam logic [8:0] SEED_ADD      = 9'd170;
    localparam logic [8:0] SEED_MOD      = 9'd192;
    localparam logic [8:0] SEED_MOD2     = 9'd384;
    localparam logic [9:0] SYM_SPAN      = 10'd96;
    localparam logic [9:0] DEC_BIAS      = 10'd480;
    // floor(x/96) = (floor(x/32) * 11) >> 5 for x below 576
    localparam logic [7:0] DIV3_MUL      = 8'd11;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_HEADER = 2'd1,
        ST_BAD_BYTE   = 2'd2
    } kts_status_t;

    typedef struct packed {
        logic load;
        logic fold_step;
        logic calc;
        logic fin;
        logic emit;
        logic head0;
        logic head1;
    } kts_cmd_t;

    typedef struct packed {
        logic in_mode;
        logic decrypt;
        logic fold_last;
        logic calc_res;
        logic calc_normal;
        logic out_free;
    } kts_stat_t;

    // A-M <-> N-Z, CR <-> DEL
    function automatic logic [7:0] sym_map(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h41 && b <= 8'h4d) r = b + 8'd13;
        else if (b >= 8'h4e && b <= 8'h5a) r = b - 8'd13;
        else if (b == 8'd13) r = 8'd127;
        else if (b == 8'd127) r = 8'd13;
        return r;
    endfunction

    function automatic logic in_alphabet(input logic [7:0] b);
        return (b == 8'd13) || (b >= 8'd32 && b <= 8'd126);
    endfunction

endpackage

>>> hdl/kts_ctrl.sv
`timescale 1ns / 1ps
module kts_ctrl import kts_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  kts_stat_t stat,
    output kts_cmd_t  cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_FOLD,
        S_HEAD0,
        S_HEAD1,
        S_CALC,
        S_FIN,
        S_EMIT
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
                if (s_tvalid) begin
                    state_next = stat.in_mode ? S_CALC : S_FOLD;
                end
            end
            S_FOLD: begin
                cmd.fold_step = 1'b1;
                if (stat.fold_last) begin
                    state_next = stat.decrypt ? S_IDLE : S_HEAD0;
                end
            end
            S_HEAD0: begin
                cmd.head0 = stat.out_free;
                if (stat.out_free) state_next = S_HEAD1;
            end
            S_HEAD1: begin
                cmd.head1 = stat.out_free;
                if (stat.out_free) state_next = S_IDLE;
            end
            S_CALC: begin
                cmd.calc = 1'b1;
                if (stat.calc_normal) state_next = S_FIN;
                else if (stat.calc_res) state_next = S_EMIT;
                else state_next = S_IDLE;
            end
            S_FIN: begin
                cmd.fin    = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                cmd.emit = stat.out_free;
                if (stat.out_free) state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

>>> hdl/kts_dp.sv
`timescale 1ns / 1ps
module kts_dp import kts_pkg::*; #(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] key_low,
    input  logic [63:0] key_high,
    input  logic [4:0]  key_length,
    input  logic        direction,
    input  logic        in_mode,
    input  logic [7:0]  in_value,
    input  kts_cmd_t    cmd,
    output kts_stat_t   stat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    localparam logic [4:0] LEN_MAX = 5'(MAX_KEY_BYTES);

    typedef enum logic [1:0] {
        HP_VERSION = 2'd0,
        HP_SALT    = 2'd1,
        HP_BODY    = 2'd2
    } hdr_pos_t;

    logic [7:0]  value_reg;
    logic [7:0]  acc_reg;
    logic [3:0]  idx_reg;
    logic [9:0]  sum_reg;
    logic [7:0]  res_byte_reg;
    kts_status_t res_status_reg;

    logic [7:0]  seed_reg;
    logic [5:0]  salt_reg;
    logic [7:0]  rc_reg;
    logic [3:0]  pos_reg;
    hdr_pos_t    hp_reg;
    logic        failed_reg;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    kts_status_t out_status_reg;
    logic        out_last_reg;

    logic [127:0] key_bytes;
    logic [4:0]   used_len;
    logic [7:0]   fold_key;
    logic [8:0]   fold_sum;
    logic [7:0]   fold_next;
    logic         out_free;
    logic         alpha;
    logic         bad_hdr;
    logic         calc_normal;
    logic         calc_res;
    logic [7:0]   pos_key;
    logic [7:0]   rc_adv;
    logic [3:0]   pos_inc;
    logic [3:0]   pos_adv;
    logic [7:0]   sym_off;
    logic [9:0]   sum_enc;
    logic [9:0]   sum_dec;
    logic [7:0]   quot_prod;
    logic [2:0]   quot;
    logic [9:0]   rem_full;
    logic [7:0]   plain_sym;
    logic [7:0]   chain_byte;
    logic [7:0]   rc_fin;

    assign key_bytes = {key_high, key_low};

    always_comb begin
        if (key_length == 5'd0) used_len = 5'd1;
        else if (key_length > LEN_MAX) used_len = LEN_MAX;
        else used_len = key_length;
    end

    // seed fold: one key byte per cycle, mod 192 by at most two subtracts
    assign fold_key = key_bytes[{idx_reg, 3'b000} +: 8];
    assign fold_sum = {1'b0, fold_key ^ acc_reg} + SEED_ADD;
    always_comb begin
        if (fold_sum >= SEED_MOD2) fold_next = 8'(fold_sum - SEED_MOD2);
        else if (fold_sum >= SEED_MOD) fold_next = 8'(fold_sum - SEED_MOD);
        else fold_next = fold_sum[7:0];
    end

    assign out_free = !out_valid_reg || m_tready;

    assign alpha   = in_alphabet(value_reg);
    assign bad_hdr = direction && (failed_reg || hp_reg == HP_VERSION);

    always_comb begin
        calc_normal = alpha && (!direction || (!failed_reg && hp_reg == HP_BODY));
        if (!direction || failed_reg) calc_res = 1'b1;
        else if (hp_reg == HP_VERSION) calc_res = (value_reg != HDR_VERSION);
        else if (hp_reg == HP_SALT) calc_res = 1'b0;
        else calc_res = 1'b1;
    end

    // count advance ahead of a symbol
    assign pos_key = key_bytes[{pos_reg, 3'b000} +: 8];
    assign rc_adv  = (pos_key ^ rc_reg) + (seed_reg ^ {2'b00, salt_reg});
    assign pos_inc = pos_reg + 4'd1;
    assign pos_adv = ({1'b0, pos_inc} >= used_len) ? 4'd0 : pos_inc;

    assign sym_off = sym_map(value_reg) - SYM_BASE;
    assign sum_enc = {2'b00, sym_off} + {2'b00, rc_adv} + {2'b00, seed_reg};
    assign sum_dec = DEC_BIAS + {2'b00, sym_off} - {2'b00, rc_adv} - {2'b00, seed_reg};

    // mod 96 of a value below 576
    assign quot_prod  = {3'b000, sum_reg[9:5]} * DIV3_MUL;
    assign quot       = quot_prod[7:5];
    assign rem_full   = sum_reg - ({7'b0, quot} * SYM_SPAN);
    assign plain_sym  = sym_map({1'b0, rem_full[6:0]} + SYM_BASE);
    assign chain_byte = direction ? plain_sym : value_reg;
    assign rc_fin     = (chain_byte ^ rc_reg) + seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg      <= '0;
            salt_reg      <= '0;
            rc_reg        <= '0;
            pos_reg       <= '0;
            hp_reg        <= HP_VERSION;
            failed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.fold_step && stat.fold_last) begin
                seed_reg   <= fold_next;
                rc_reg     <= fold_next + CNT_INIT;
                pos_reg    <= '0;
                failed_reg <= 1'b0;
                if (!direction) begin
                    salt_reg <= value_reg[5:0];
                    hp_reg   <= HP_BODY;
                end else begin
                    hp_reg <= HP_VERSION;
                end
            end
            if (cmd.calc) begin
                if (calc_normal) begin
                    rc_reg   <= rc_adv;
                    salt_reg <= salt_reg + 6'd1;
                    pos_reg  <= pos_adv;
                end else if (direction && !failed_reg) begin
                    if (hp_reg == HP_VERSION) begin
                        hp_reg <= HP_SALT;
                        if (value_reg != HDR_VERSION) failed_reg <= 1'b1;
                    end else if (hp_reg == HP_SALT) begin
                        salt_reg <= 6'(value_reg - HDR_SALT_BASE);
                        hp_reg   <= HP_BODY;
                    end
                end
            end
            if (cmd.fin) begin
                rc_reg <= rc_fin;
            end
            if (cmd.head0 || cmd.head1 || cmd.emit) out_valid_reg <= 1'b1;
            else if (m_tready) out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            value_reg <= in_value;
            acc_reg   <= '0;
            idx_reg   <= '0;
        end
        if (cmd.fold_step) begin
            acc_reg <= fold_next;
            idx_reg <= idx_reg + 4'd1;
        end
        if (cmd.calc) begin
            sum_reg <= direction ? sum_dec : sum_enc;
            if (bad_hdr) begin
                res_byte_reg   <= '0;
                res_status_reg <= ST_BAD_HEADER;
            end else begin
                res_byte_reg   <= value_reg;
                res_status_reg <= ST_BAD_BYTE;
            end
        end
        if (cmd.fin) begin
            res_byte_reg   <= plain_sym;
            res_status_reg <= ST_OK;
        end
        if (cmd.head0) begin
            out_byte_reg   <= HDR_VERSION;
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b0;
        end else if (cmd.head1) begin
            out_byte_reg   <= HDR_SALT_BASE + {2'b00, salt_reg};
            out_status_reg <= ST_OK;
            out_last_reg   <= 1'b1;
        end else if (cmd.emit) begin
            out_byte_reg   <= res_byte_reg;
            out_status_reg <= res_status_reg;
            out_last_reg   <= 1'b1;
        end
    end

    always_comb begin
        stat.in_mode     = in_mode;
        stat.decrypt     = direction;
        stat.fold_last   = ({1'b0, idx_reg} == (used_len - 5'd1));
        stat.calc_res    = calc_res;
        stat.calc_normal = calc_normal;
        stat.out_free    = out_free;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

>>> hdl/keyed_text_stream_cipher_core.sv
`timescale 1ns / 1ps
// Keyed text stream cipher over the 96-symbol printable alphabet.
// Input stream: s_tuser = 0 starts a message (s_tdata low 6 bits = salt when
// encrypting), s_tuser = 1 carries one message byte in s_tdata.
// Output stream: m_tdata = header or text byte, m_tuser = status
// (0 ok, 1 bad header, 2 byte outside alphabet), m_tlast ends each run.
// Key, key length and direction sit in APB registers at 0x00, 0x08, 0x10,
// 0x18; write them only while the block is idle.
// A text byte passes through accept, count step, mod-96 step and output load,
// the output load waiting until the output register frees up; a new byte is
// accepted only after that load. Rejected bytes and bad header bytes skip the
// mod-96 step; a good header byte gives no transfer.
// A start item folds one key byte per cycle, using n key bytes (0 read as 1,
// capped at MAX_KEY_BYTES); when encrypting it then loads the two header
// transfers.
// One output register sits between the core and m_*: a new item is taken
// while a result waits; when the receiver stalls the core holds its next
// result until the register frees up, and input then stops.
// Reset clears the cipher state, the key and direction registers (key length resets to 1) and the output valid.
module keyed_text_stream_cipher_core import kts_pkg::*; #(
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    typedef enum logic [1:0] {
        REG_KEY_LOW  = 2'd0,
        REG_KEY_HIGH = 2'd1,
        REG_KEY_LEN  = 2'd2,
        REG_DIR      = 2'd3
    } reg_idx_t;

    logic [63:0] key_low_reg;
    logic [63:0] key_high_reg;
    logic [4:0]  key_length_reg;
    logic        direction_reg;
    reg_idx_t    reg_idx;
    logic        cfg_write;
    kts_cmd_t    cmd;
    kts_stat_t   stat;

    assign pready    = 1'b1;
    assign reg_idx   = reg_idx_t'(paddr[4:3]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= 5'd1;
            direction_reg  <= 1'b0;
        end else if (cfg_write) begin
            case (reg_idx)
                REG_KEY_LOW:  key_low_reg    <= pwdata;
                REG_KEY_HIGH: key_high_reg   <= pwdata;
                REG_KEY_LEN:  key_length_reg <= pwdata[4:0];
                REG_DIR:      direction_reg  <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_KEY_LOW:  prdata = key_low_reg;
            REG_KEY_HIGH: prdata = key_high_reg;
            REG_KEY_LEN:  prdata = {59'b0, key_length_reg};
            REG_DIR:      prdata = {63'b0, direction_reg};
            default:      prdata = '0;
        endcase
    end

    kts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    kts_dp #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .key_low    (key_low_reg),
        .key_high   (key_high_reg),
        .key_length (key_length_reg),
        .direction  (direction_reg),
        .in_mode    (s_tuser),
        .in_value   (s_tdata),
        .cmd        (cmd),
        .stat       (stat),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

>>> bench/kts_cipher_checker.sv
`timescale 1ns / 1ps
package kts_tb_pkg;

    localparam logic MODE_START = 1'b0;
    localparam logic MODE_TEXT  = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [4:0] ADDR_KEY_LO  = 5'h00;
    localparam logic [4:0] ADDR_KEY_HI  = 5'h08;
    localparam logic [4:0] ADDR_KEY_LEN = 5'h10;
    localparam logic [4:0] ADDR_DIR     = 5'h18;

endpackage

module kts_cipher_checker import kts_pkg::*, kts_tb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic        s_tuser,   // [0] mode
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,   // [7:0] out_byte
    input  logic [1:0]  m_tuser,   // [1:0] status
    input  logic        m_tlast,
    output int          bad_results,
    output int          results_due
);

    localparam int FOLD_ADD   = 170;
    localparam int FOLD_MOD   = 192;
    localparam int SYM_COUNT  = 96;
    localparam int SYM_FIRST  = 32;
    localparam int DEC_OFFSET = 480;
    localparam int MAX_REPORTS = 100;

    typedef enum logic [1:0] {
        HP_VERSION = 2'd0,
        HP_SALT    = 2'd1,
        HP_BODY    = 2'd2
    } hdr_pos_t;

    typedef struct packed {
        logic [7:0]  text;
        kts_status_t status;
        logic        last;
    } cipher_out_t;

    // register copies
    logic [63:0] key_lo;
    logic [63:0] key_hi;
    logic [4:0]  key_len;
    logic        dir;

    // cipher state
    logic [7:0] seed;
    logic [7:0] count;
    logic [5:0] salt;
    logic [3:0] key_pos;
    hdr_pos_t   hdr_pos;
    logic       hdr_bad;

    cipher_out_t cipher_out_q[$];
    cipher_out_t want;

    // A-M <-> N-Z, CR <-> DEL
    function automatic logic [7:0] swap_sym(input logic [7:0] b);
        if (b >= 8'h41 && b <= 8'h4d) return b + 8'd13;
        if (b >= 8'h4e && b <= 8'h5a) return b - 8'd13;
        if (b == 8'h0d) return 8'h7f;
        if (b == 8'h7f) return 8'h0d;
        return b;
    endfunction

    function automatic logic printable(input logic [7:0] b);
        return (b == 8'h0d) || (b >= 8'h20 && b <= 8'h7e);
    endfunction

    function automatic int key_span();
        if (key_len == 5'd0) return 1;
        if (key_len > MAX_KEY_BYTES_DEF) return MAX_KEY_BYTES_DEF;
        return int'(key_len);
    endfunction

    function automatic logic [7:0] key_at(input int i);
        if (i < 8) return key_lo[8*i +: 8];
        return key_hi[8*(i-8) +: 8];
    endfunction

    function automatic void push_out(input logic [7:0] text, input kts_status_t st,
                                     input logic last);
        cipher_out_t r;
        r.text = text;
        r.status = st;
        r.last = last;
        cipher_out_q.push_back(r);
    endfunction

    // count update ahead of every text symbol
    function automatic void step_count();
        count = (key_at(int'(key_pos)) ^ count) + (seed ^ {2'b00, salt});
        salt = salt + 6'd1;
        key_pos = key_pos + 4'd1;
        if (int'(key_pos) >= key_span()) key_pos = 4'd0;
    endfunction

    function automatic void cipher_step(input logic md, input logic [7:0] v);
        int s;
        int r;
        int i;
        logic [7:0] p;
        if (md == MODE_START) begin
            s = 0;
            for (i = 0; i < key_span(); i++)
                s = ((int'(key_at(i)) ^ s) + FOLD_ADD) % FOLD_MOD;
            seed = s[7:0];
            count = seed + CNT_INIT;
            key_pos = 4'd0;
            hdr_bad = 1'b0;
            if (dir == DIR_ENCRYPT) begin
                salt = v[5:0];
                hdr_pos = HP_BODY;
                push_out(HDR_VERSION, ST_OK, 1'b0);
                push_out(HDR_SALT_BASE + {2'b00, salt}, ST_OK, 1'b1);
            end else begin
                hdr_pos = HP_VERSION;
            end
            return;
        end
        if (dir == DIR_ENCRYPT) begin
            if (!printable(v)) begin
                push_out(v, ST_BAD_BYTE, 1'b1);
                return;
            end
            step_count();
            r = int'(swap_sym(v)) - SYM_FIRST + int'(count) + int'(seed);
            r = r % SYM_COUNT + SYM_FIRST;
            push_out(swap_sym(r[7:0]), ST_OK, 1'b1);
            count = (v ^ count) + seed;
            return;
        end
        if (hdr_bad) begin
            push_out(8'h00, ST_BAD_HEADER, 1'b1);
            return;
        end
        case (hdr_pos)
            HP_VERSION: begin
                hdr_pos = HP_SALT;
                if (v != HDR_VERSION) begin
                    hdr_bad = 1'b1;
                    push_out(8'h00, ST_BAD_HEADER, 1'b1);
                end
            end
            HP_SALT: begin
                p = v - HDR_SALT_BASE;
                salt = p[5:0];
                hdr_pos = HP_BODY;
            end
            default: begin
                if (!printable(v)) begin
                    push_out(v, ST_BAD_BYTE, 1'b1);
                    return;
                end
                step_count();
                r = (int'(swap_sym(v)) - SYM_FIRST + DEC_OFFSET
                     - (int'(count) + int'(seed))) % SYM_COUNT + SYM_FIRST;
                p = swap_sym(r[7:0]);
                push_out(p, ST_OK, 1'b1);
                count = (p ^ count) + seed;
            end
        endcase
    endfunction

    function automatic void note_bad(input string field, input logic [7:0] exp_v,
                                     input logic [7:0] act_v);
        bad_results++;
        if (bad_results <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            key_lo = '0;
            key_hi = '0;
            key_len = 5'd1;
            dir = DIR_ENCRYPT;
            seed = '0;
            count = '0;
            salt = '0;
            key_pos = '0;
            hdr_pos = HP_VERSION;
            hdr_bad = 1'b0;
            cipher_out_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr)
                    ADDR_KEY_LO:  key_lo = pwdata;
                    ADDR_KEY_HI:  key_hi = pwdata;
                    ADDR_KEY_LEN: key_len = pwdata[4:0];
                    ADDR_DIR:     dir = pwdata[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                cipher_step(s_tuser, s_tdata);
            if (m_tvalid && m_tready) begin
                if (cipher_out_q.size() == 0) begin
                    bad_results++;
                    if (bad_results <= MAX_REPORTS)
                        $display("%0t: stray transfer, expected none actual %h/%h/%b",
                                 $time, m_tdata, m_tuser, m_tlast);
                end else begin
                    want = cipher_out_q.pop_front();
                    if (m_tdata !== want.text) note_bad("out_byte", want.text, m_tdata);
                    if (m_tuser !== want.status)
                        note_bad("status", {6'b0, want.status}, {6'b0, m_tuser});
                    if (m_tlast !== want.last)
                        note_bad("last", {7'b0, want.last}, {7'b0, m_tlast});
                end
            end
        end
        results_due <= cipher_out_q.size();
    end

endmodule

>>> bench/keyed_text_stream_cipher_core_tb.sv
`timescale 1ns / 1ps
module keyed_text_stream_cipher_core_tb;
    import kts_pkg::*;
    import kts_tb_pkg::*;

    localparam int ITEM_TARGET = 1900;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES = 300;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] value
    logic        s_tuser = 1'b0; // [0] mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] out_byte
    logic [1:0]  m_tuser;        // [1:0] status
    logic        m_tlast;

    int   bad_results;
    int   results_due;
    int   items_sent = 0;
    logic calm = 1'b0;
    logic hold_req = 1'b0;
    int   hold_left = 0;
    logic cur_dir = DIR_ENCRYPT;

    always begin
        aclk = 1'b0;
        #1;
        aclk = 1'b1;
        #1;
    end

    keyed_text_stream_cipher_core uut (.*);

    kts_cipher_checker chk (.*);

    // receiver: random back-pressure, a long hold when requested
    always @(posedge aclk) begin
        if (hold_req) begin
            hold_req <= 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (calm) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(99) >= 32);
        end
    end

    initial begin
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic send_item(input logic md, input logic [7:0] val);
        if (!calm) begin
            while ($urandom_range(99) < 32) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= md;
        s_tdata <= val;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // sender stops until every pending result is out, then lets the core settle
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [4:0] addr, input logic [63:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
    endtask

    task automatic write_config(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic d);
        wait_drain();
        apb_write(ADDR_KEY_LO, lo);
        apb_write(ADDR_KEY_HI, hi);
        apb_write(ADDR_KEY_LEN, {59'b0, len});
        apb_write(ADDR_DIR, {63'b0, d});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_dir = d;
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(99) < 8) return 8'($urandom_range(255));
        if ($urandom_range(31) == 0) return 8'h0d;
        return 8'($urandom_range(126, 32));
    endfunction

    task automatic send_message(input int nbytes);
        int i;
        send_item(MODE_START, 8'($urandom_range(255)));
        if (cur_dir == DIR_DECRYPT) begin
            if ($urandom_range(15) == 0) send_item(MODE_TEXT, 8'($urandom_range(255)));
            else send_item(MODE_TEXT, HDR_VERSION);
            send_item(MODE_TEXT, 8'($urandom_range(255)));
        end
        for (i = 0; i < nbytes; i++) send_item(MODE_TEXT, text_byte());
    endtask

    initial begin
        int phase;
        int msgs;
        int m;
        logic [4:0] len;
        logic d;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // text before any start, reset settings
        send_item(MODE_TEXT, 8'h41);
        send_item(MODE_TEXT, 8'h0d);
        send_item(MODE_TEXT, 8'h7f);
        send_item(MODE_TEXT, 8'h00);
        send_item(MODE_TEXT, 8'hff);

        // all-ones key at full length, top salt, map and alphabet edges
        write_config('1, '1, 5'd16, DIR_ENCRYPT);
        send_item(MODE_START, 8'hff);
        send_item(MODE_TEXT, 8'h20);
        send_item(MODE_TEXT, 8'h7e);
        send_item(MODE_TEXT, 8'h4d);
        send_item(MODE_TEXT, 8'h4e);
        send_item(MODE_TEXT, 8'h5a);
        send_item(MODE_TEXT, 8'h1f);
        send_item(MODE_TEXT, 8'h80);

        // zero length is taken as one; good header, then a bad version
        write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'd0, DIR_DECRYPT);
        send_item(MODE_START, 8'h00);
        send_item(MODE_TEXT, HDR_VERSION);
        send_item(MODE_TEXT, 8'h7f);
        send_item(MODE_TEXT, 8'h0d);
        send_item(MODE_TEXT, 8'h61);
        send_item(MODE_TEXT, 8'hc3);
        send_item(MODE_START, 8'h55);
        send_item(MODE_TEXT, 8'h22);
        send_item(MODE_TEXT, 8'h41);

        // length above the maximum
        write_config({$urandom, $urandom}, {$urandom, $urandom}, 5'd31, DIR_DECRYPT);
        send_item(MODE_TEXT, 8'h41);
        send_item(MODE_START, 8'h00);
        send_item(MODE_TEXT, HDR_VERSION);
        send_item(MODE_TEXT, 8'h20);
        send_item(MODE_TEXT, 8'h7e);

        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(7))
                0: len = 5'd1;
                1: len = 5'd16;
                2: len = 5'd0;
                3: len = 5'($urandom_range(31, 17));
                default: len = 5'($urandom_range(16, 1));
            endcase
            d = (phase == 1) ? DIR_ENCRYPT : 1'($urandom_range(1));
            write_config({$urandom, $urandom}, {$urandom, $urandom}, len, d);
            calm <= (phase == 2);
            if (phase == 1) hold_req <= 1'b1;
            msgs = $urandom_range(6, 2);
            for (m = 0; m < msgs; m++) begin
                if (phase != 1 && $urandom_range(9) == 0) begin
                    repeat ($urandom_range(4, 1))
                        send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
                end else begin
                    send_message((phase == 1 && m == 0) ? 60 : $urandom_range(30, 1));
                end
            end
            phase++;
        end

        wait_drain();
        if (bad_results == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
